/* rtl/msa_pkg.sv */
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants and types of the min-heap seat allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

	localparam int MAX_SEATS = 256;
	localparam int ADDR_W    = $clog2(MAX_SEATS);
	localparam int CNT_W     = $clog2(MAX_SEATS + 1);
	localparam int IDX_W     = ADDR_W + 2;	// room for 2*slot+2
	localparam int SEAT_W    = 9;
	localparam int STAT_W    = 2;

	localparam logic [SEAT_W-1:0] SEAT_COUNT_RESET = SEAT_W'(256);

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic MODE_RESERVE   = 1'b0;
	localparam logic MODE_UNRESERVE = 1'b1;

	// the requests to the heap store for a cycle
	typedef struct packed {
		logic [ADDR_W-1:0] ra;
		logic [ADDR_W-1:0] rb;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [SEAT_W-1:0] wdata;
		logic              clr;
	} mem_req_t;

endpackage

/* rtl/msa_heap_mem.sv */
// ----------------------------------------------------------------------------
// msa_heap_mem
// Heap store: two registered read ports, one write port. A per-entry valid
// bit makes an unwritten entry read as its index plus one (the refilled heap).
// ----------------------------------------------------------------------------
module msa_heap_mem import msa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [SEAT_W-1:0] rd_a,
	output logic [SEAT_W-1:0] rd_b
);

	logic [SEAT_W-1:0]    mem [MAX_SEATS];
	logic [MAX_SEATS-1:0] valid_q;
	logic [SEAT_W-1:0]    dat_a_q, dat_b_q;
	logic [ADDR_W-1:0]    adr_a_q, adr_b_q;
	logic                 vld_a_q, vld_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		dat_a_q <= mem[req.ra];
		dat_b_q <= mem[req.rb];
		adr_a_q <= req.ra;
		adr_b_q <= req.rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			vld_a_q <= valid_q[req.ra];
			vld_b_q <= valid_q[req.rb];
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
		end
	end

	assign rd_a = vld_a_q ? dat_a_q : SEAT_W'({1'b0, adr_a_q} + (ADDR_W+1)'(1));
	assign rd_b = vld_b_q ? dat_b_q : SEAT_W'({1'b0, adr_b_q} + (ADDR_W+1)'(1));

endmodule

/* rtl/min_heap_seat_allocator.sv */
// ----------------------------------------------------------------------------
// min_heap_seat_allocator
// Hands out the smallest free seat from a binary min-heap and takes seats back.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------
//  request  | start, busy            | mode, seat_number
//  result   | done (1-cycle strobe)  | seat, status
//  config   | cfg_we                 | cfg_wdata (seat count)
//
//  Reserve: the root and the last entry are read, and the last entry sifts down
//  from the root, each level stepping to the smaller child while it is smaller.
//  Unreserve: the new entry sifts up while its parent is larger.
//  Each level is one read of the store, one compare-and-write.
//  Empty or full requests answer in the next cycle without leaving idle.
//  Reset and a config write refill the heap at once (valid bits cleared).
//  The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module min_heap_seat_allocator import msa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [SEAT_W-1:0] seat_number,
	output logic              done,
	output logic [SEAT_W-1:0] seat,
	output logic [STAT_W-1:0] status,
	input  logic              cfg_we,
	input  logic [SEAT_W-1:0] cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_POP   = 3'd1;
	localparam logic [2:0] S_DN_RD = 3'd2;
	localparam logic [2:0] S_DN_EV = 3'd3;
	localparam logic [2:0] S_UP_RD = 3'd4;
	localparam logic [2:0] S_UP_EV = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q, cap_q, cfg_sat, reset_sat, cnt_m1;
	logic [ADDR_W-1:0] slot_q, parent, cidx;
	logic [SEAT_W-1:0] val_q, res_q, seat_q, cmin;
	logic [STAT_W-1:0] status_q;
	logic              done_q, accept, l_in, r_in, use_b;
	logic [IDX_W-1:0]  lchild, rchild, cnt_x;
	logic [SEAT_W-1:0] rd_a, rd_b;
	mem_req_t          req;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign seat   = seat_q;
	assign status = status_q;

	// capacity saturates at the store depth
	assign cfg_sat   = ({1'b0, cfg_wdata} > (SEAT_W+1)'(MAX_SEATS)) ? CNT_W'(MAX_SEATS)
	                                                               : CNT_W'(cfg_wdata);
	assign reset_sat = ({1'b0, SEAT_COUNT_RESET} > (SEAT_W+1)'(MAX_SEATS))
	                   ? CNT_W'(MAX_SEATS) : CNT_W'(SEAT_COUNT_RESET);

	assign cnt_m1 = count_q - CNT_W'(1);
	assign cnt_x  = IDX_W'(count_q);
	assign lchild = {1'b0, slot_q, 1'b1};
	assign rchild = lchild + IDX_W'(1);
	assign l_in   = lchild < cnt_x;
	assign r_in   = rchild < cnt_x;
	assign parent = (slot_q - ADDR_W'(1)) >> 1;
	// left wins ties
	assign use_b  = r_in && (rd_b < rd_a);
	assign cmin   = use_b ? rd_b : rd_a;
	assign cidx   = use_b ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];

	always_comb begin
		req       = '0;
		req.waddr = slot_q;
		req.wdata = val_q;
		req.clr   = cfg_we;
		unique case (state_q)
			S_IDLE: begin
				if (accept && mode == MODE_RESERVE) begin
					req.ra = '0;
					req.rb = cnt_m1[ADDR_W-1:0];
				end
			end
			S_POP: begin
			end
			S_DN_RD: begin
				req.ra = lchild[ADDR_W-1:0];
				req.rb = rchild[ADDR_W-1:0];
				req.we = !l_in;
			end
			S_DN_EV: begin
				req.we    = 1'b1;
				req.wdata = (cmin < val_q) ? cmin : val_q;
			end
			S_UP_RD: begin
				req.ra = parent;
				req.we = (slot_q == '0);
			end
			S_UP_EV: begin
				req.we    = 1'b1;
				req.wdata = (rd_a > val_q) ? rd_a : val_q;
			end
			default: begin
			end
		endcase
	end

	msa_heap_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= reset_sat;
			cap_q    <= reset_sat;
			done_q   <= 1'b0;
			slot_q   <= '0;
			val_q    <= '0;
			res_q    <= '0;
			seat_q   <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cap_q   <= cfg_sat;
				count_q <= cfg_sat;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_RESERVE) begin
							if (count_q == '0) begin
								done_q   <= 1'b1;
								status_q <= ST_EMPTY;
								seat_q   <= '0;
							end else begin
								count_q <= cnt_m1;
								state_q <= S_POP;
							end
						end else begin
							if (count_q >= cap_q) begin
								done_q   <= 1'b1;
								status_q <= ST_FULL;
								seat_q   <= '0;
							end else begin
								val_q   <= seat_number;
								slot_q  <= count_q[ADDR_W-1:0];
								count_q <= count_q + CNT_W'(1);
								state_q <= S_UP_RD;
							end
						end
					end
				end
				S_POP: begin
					// root is the answer, the last entry sifts down from the root
					res_q   <= rd_a;
					val_q   <= rd_b;
					slot_q  <= '0;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					if (!l_in) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						seat_q   <= res_q;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DN_EV;
					end
				end
				S_DN_EV: begin
					if (cmin < val_q) begin
						slot_q  <= cidx;
						state_q <= S_DN_RD;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						seat_q   <= res_q;
						state_q  <= S_IDLE;
					end
				end
				S_UP_RD: begin
					if (slot_q == '0) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						seat_q   <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_UP_EV;
					end
				end
				S_UP_EV: begin
					if (rd_a > val_q) begin
						slot_q  <= parent;
						state_q <= S_UP_RD;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						seat_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("heap count exceeds capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while an item is in flight");

	a_fail_no_seat: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != ST_OK |-> seat_q == '0)
		else $error("failed request returned a seat");

	a_empty_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_RESERVE && count_q == '0 && !cfg_we
		|=> done_q && status_q == ST_EMPTY)
		else $error("reserve on empty heap not answered empty");

endmodule
